>>> hw/rtl/sgrb_pkg.sv
`timescale 1ns / 1ps
package sgrb_pkg;
   localparam int WINDOW = 128;
   localparam int HIST_DEPTH = 32;
   localparam int PRINT_WIDTH = 64;
   localparam int SEQ_W = 64;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int HIDX_W = $clog2(HIST_DEPTH);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int HCNT_W = $clog2(HIST_DEPTH + 1);
   localparam int MAXRES = 64;
   localparam int RES_W = $clog2(MAXRES + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXBUF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AHEAD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIST = 2'd3;

   typedef enum logic [3:0] {
      K_APPLIED = 4'd0, K_DUP_APPLIED = 4'd1, K_LATE_DUP = 4'd2,
      K_DUP_BUF = 4'd3, K_GAP_BUF = 4'd4, K_APPLIED_MISMATCH = 4'd5,
      K_BUF_MISMATCH = 4'd6, K_BEYOND = 4'd7, K_FULL = 4'd8, K_EXHAUSTED = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DECIDE, ST_DRAIN_READ, ST_DRAIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic decide;
      logic drain_read;
      logic drain;
   } cmd_type;

   typedef struct packed {
      logic more;
   } status_type;
endpackage

>>> hw/rtl/sgrb_if.sv
`timescale 1ns / 1ps
interface sgrb_req_if;
   import sgrb_pkg::*;
   logic valid;
   logic ready;
   logic [SEQ_W-1:0] seq_number;
   logic [63:0] fingerprint;
   modport source(output valid, seq_number, fingerprint, input ready);
   modport sink(input valid, seq_number, fingerprint, output ready);
endinterface

interface sgrb_rsp_if;
   import sgrb_pkg::*;
   logic valid;
   logic ready;
   logic [3:0] kind;
   logic [SEQ_W-1:0] out_sequence;
   logic [63:0] out_fingerprint;
   logic [SEQ_W-1:0] expected_now;
   logic last_flag;
   modport source(output valid, kind, out_sequence, out_fingerprint, expected_now,
      last_flag, input ready);
   modport sink(input valid, kind, out_sequence, out_fingerprint, expected_now,
      last_flag, output ready);
endinterface

interface sgrb_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/sequence_gap_reorder_buffer_core.sv
`timescale 1ns / 1ps
// Sequence gap reorder buffer.
// The req channel takes one word per packet: a sequence number and a fingerprint.
// The rsp channel gives one or more result words per packet; last_flag marks
// the final word of a packet. An in-order packet gives an apply result and then
// one result per buffered successor that is released in order, up to 64 in all.
// The csr channel writes the four configuration registers by index; it is always
// ready and is meant to be written while the block is idle.
// An accepted packet passes the registered gap and history memory reads and then
// the decision before its first result word. Each drained successor passes its gap
// memory read, its apply and its result word. The block handles one packet at a
// time, so the next req word is taken once the last result word has been taken.
// When the receiver stalls, the result word holds and no new packet is taken.
// Reset loads the default registers, sets the expected number to zero and empties
// the gap buffer and history; no clearing pass runs.
module sequence_gap_reorder_buffer_core (
   input  logic clock,
   input  logic reset,
   sgrb_req_if.sink req,
   sgrb_rsp_if.source rsp,
   sgrb_csr_if.sink csr
);
   import sgrb_pkg::*;
   cmd_type cmd;
   status_type status;

   assign csr.ready = 1'b1;

   sgrb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(status), .cmd(cmd)
   );

   sgrb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .seq_number(req.seq_number), .fingerprint(req.fingerprint),
      .csr_write(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .kind(rsp.kind), .out_sequence(rsp.out_sequence),
      .out_fingerprint(rsp.out_fingerprint), .expected_now(rsp.expected_now),
      .last_flag(rsp.last_flag)
   );
endmodule

>>> hw/rtl/sgrb_ctrl.sv
`timescale 1ns / 1ps
module sgrb_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sgrb_pkg::status_type status,
   output sgrb_pkg::cmd_type cmd
);
   import sgrb_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_READ;
         ST_READ: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_DRAIN_READ: state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = status.more ? ST_DRAIN_READ : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_READ: cmd.read = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_DRAIN_READ: cmd.drain_read = 1'b1;
         ST_DRAIN: cmd.drain = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

>>> hw/rtl/sgrb_datapath.sv
`timescale 1ns / 1ps
module sgrb_datapath (
   input  logic clock,
   input  logic reset,
   input  sgrb_pkg::cmd_type cmd,
   output sgrb_pkg::status_type status,
   input  logic [sgrb_pkg::SEQ_W-1:0] seq_number,
   input  logic [63:0] fingerprint,
   input  logic csr_write,
   input  logic [sgrb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_data,
   output logic [3:0] kind,
   output logic [sgrb_pkg::SEQ_W-1:0] out_sequence,
   output logic [63:0] out_fingerprint,
   output logic [sgrb_pkg::SEQ_W-1:0] expected_now,
   output logic last_flag
);
   import sgrb_pkg::*;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   logic [5:0] maxbuf_ff;
   logic [6:0] ahead_ff;
   logic [5:0] hlen_ff;
   logic [SEQ_W-1:0] exp_ff;
   logic [WINDOW-1:0] gvalid_ff;
   logic [CNT_W-1:0] gcount_ff;
   logic [HCNT_W-1:0] applied_ff;
   logic [PRINT_WIDTH-1:0] gmem [WINDOW];
   logic [PRINT_WIDTH-1:0] hmem [HIST_DEPTH];
   logic [PRINT_WIDTH-1:0] grd_ff, hrd_ff;
   logic [SEQ_W-1:0] seq_ff;
   logic [PRINT_WIDTH-1:0] fp_ff;
   logic [RES_W-1:0] nres_ff;
   logic [3:0] kind_ff;
   logic [SEQ_W-1:0] oseq_ff, oexp_ff;
   logic [PRINT_WIDTH-1:0] ofp_ff;
   logic last_ff;

   logic [SEQ_W-1:0] diff, back;
   logic [SLOT_W-1:0] sslot, eslot;
   logic [HCNT_W-1:0] hlim, app_inc;
   logic gwr, hwr;
   logic [SLOT_W-1:0] gwa;
   logic [PRINT_WIDTH-1:0] gwd, hwd;
   logic [HIDX_W-1:0] hwa;

   assign diff = seq_ff - exp_ff;
   assign back = exp_ff - seq_ff;
   assign sslot = seq_ff[SLOT_W-1:0];
   assign eslot = exp_ff[SLOT_W-1:0];
   assign hlim = (hlen_ff > 6'(HIST_DEPTH)) ? HCNT_W'(HIST_DEPTH) : HCNT_W'(hlen_ff);
   assign app_inc = (applied_ff + 1'b1 > hlim) ? hlim : applied_ff + 1'b1;
   assign hwa = exp_ff[HIDX_W-1:0];

   always_comb begin
      gwr = 1'b0;
      gwa = sslot;
      gwd = fp_ff;
      hwr = 1'b0;
      hwd = fp_ff;
      if (cmd.decide && seq_ff > exp_ff && !(diff < SEQ_W'(WINDOW) && gvalid_ff[sslot])
          && !(diff > SEQ_W'(ahead_ff) || diff >= SEQ_W'(WINDOW))
          && !(gcount_ff >= CNT_W'(maxbuf_ff)))
         gwr = 1'b1;
      if (cmd.decide && seq_ff == exp_ff && exp_ff != SEQ_MAX) hwr = 1'b1;
      if (cmd.drain && exp_ff != SEQ_MAX) begin
         hwr = 1'b1;
         hwd = grd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (gwr) gmem[gwa] <= gwd;
      if (hwr) hmem[hwa] <= hwd;
      if (cmd.read) hrd_ff <= hmem[seq_ff[HIDX_W-1:0]];
      grd_ff <= gmem[cmd.read ? sslot : eslot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxbuf_ff <= 6'd8;
         ahead_ff <= 7'd64;
         hlen_ff <= 6'd16;
         exp_ff <= '0;
         gvalid_ff <= '0;
         gcount_ff <= '0;
         applied_ff <= '0;
         status.more <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_START: begin
                  exp_ff <= csr_data;
                  gvalid_ff <= '0;
                  gcount_ff <= '0;
                  applied_ff <= '0;
               end
               CSR_MAXBUF: maxbuf_ff <= csr_data[5:0];
               CSR_AHEAD: ahead_ff <= csr_data[6:0];
               CSR_HIST: hlen_ff <= csr_data[5:0];
               default: ;
            endcase
         end
         if (gwr) begin
            gvalid_ff[sslot] <= 1'b1;
            gcount_ff <= gcount_ff + 1'b1;
         end
         if (hwr) begin
            applied_ff <= app_inc;
            exp_ff <= exp_ff + 1'b1;
         end
         if (cmd.drain && exp_ff != SEQ_MAX) begin
            gvalid_ff[eslot] <= 1'b0;
            if (gcount_ff != '0) gcount_ff <= gcount_ff - 1'b1;
         end
         if (cmd.decide)
            status.more <= hwr && gvalid_ff[SLOT_W'(exp_ff + 1'b1)];
         if (cmd.drain)
            status.more <= exp_ff != SEQ_MAX && gvalid_ff[SLOT_W'(exp_ff + 1'b1)]
               && nres_ff < RES_W'(MAXRES - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff <= seq_number;
         fp_ff <= fingerprint[PRINT_WIDTH-1:0];
      end
      if (cmd.decide) begin
         nres_ff <= RES_W'(1);
         oseq_ff <= seq_ff;
         ofp_ff <= fp_ff;
         oexp_ff <= exp_ff;
         last_ff <= 1'b1;
         if (seq_ff < exp_ff) begin
            if (back <= SEQ_W'(applied_ff))
               kind_ff <= (hrd_ff != fp_ff) ? K_APPLIED_MISMATCH : K_DUP_APPLIED;
            else kind_ff <= K_LATE_DUP;
         end else if (seq_ff == exp_ff) begin
            if (exp_ff == SEQ_MAX) kind_ff <= K_EXHAUSTED;
            else begin
               kind_ff <= K_APPLIED;
               oexp_ff <= exp_ff + 1'b1;
               last_ff <= !gvalid_ff[SLOT_W'(exp_ff + 1'b1)];
            end
         end else if (diff < SEQ_W'(WINDOW) && gvalid_ff[sslot])
            kind_ff <= (grd_ff != fp_ff) ? K_BUF_MISMATCH : K_DUP_BUF;
         else if (diff > SEQ_W'(ahead_ff) || diff >= SEQ_W'(WINDOW)) kind_ff <= K_BEYOND;
         else if (gcount_ff >= CNT_W'(maxbuf_ff)) kind_ff <= K_FULL;
         else kind_ff <= K_GAP_BUF;
      end
      if (cmd.drain) begin
         nres_ff <= nres_ff + 1'b1;
         oseq_ff <= exp_ff;
         ofp_ff <= grd_ff;
         if (exp_ff == SEQ_MAX) begin
            kind_ff <= K_EXHAUSTED;
            oexp_ff <= exp_ff;
            last_ff <= 1'b1;
         end else begin
            kind_ff <= K_APPLIED;
            oexp_ff <= exp_ff + 1'b1;
            last_ff <= !(gvalid_ff[SLOT_W'(exp_ff + 1'b1)]
               && nres_ff < RES_W'(MAXRES - 1));
         end
      end
   end

   assign kind = kind_ff;
   assign out_sequence = oseq_ff;
   assign out_fingerprint = 64'(ofp_ff);
   assign expected_now = oexp_ff;
   assign last_flag = last_ff;
endmodule

>>> hw/rtl/sgrb_checker.sv
`timescale 1ns / 1ps
module sgrb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] rsp_kind,
   input logic rsp_last_flag
);
   import sgrb_pkg::*;
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req ready while result pending");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= K_EXHAUSTED) else $error("bad kind");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != K_APPLIED) |-> rsp_last_flag) else $error("non-apply not last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_kind))
      else $error("result dropped");
endmodule

bind sequence_gap_reorder_buffer_core sgrb_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
   .rsp_last_flag(rsp.last_flag)
);
